FILE: rtl/core/btda_pkg.sv
// Shared types, constants and cell control for the binary to decimal ASCII converter.
package btda_pkg;

    // Fixed widths of the request fields.
    localparam int MAG_WIDTH  = 64;
    localparam int CHAR_WIDTH = 6;

    // Default sizing handed to the top level.
    localparam int DEF_MAGNITUDE_BITS = 64;
    localparam int DEF_MAX_DIGITS     = 20;

    // Character codes.
    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 6'd45;

    // A decimal digit at or above this value is corrected before it doubles.
    localparam logic [3:0] DABBLE_LIMIT = 4'd5;
    localparam logic [3:0] DABBLE_ADD   = 4'd3;

    // One number to convert.
    typedef struct packed {
        logic                 is_negative;
        logic [MAG_WIDTH-1:0] magnitude;
    } num_req_t;

    // One character of the decimal text.
    typedef struct packed {
        logic [CHAR_WIDTH-1:0] text_char;
        logic                  last_char;
    } char_req_t;

    // Operation applied to every digit cell in a cycle.
    typedef struct packed {
        logic clear;     // load zero
        logic dabble;    // correct, then double and take the bit from below
        logic shift_up;  // take the digit of the cell below
    } cell_ctrl_t;

endpackage

FILE: rtl/core/btda_cell.sv
// One decimal digit cell of the shift-and-add-three conversion chain.
module btda_cell
(
    input  logic                 clk,
    input  btda_pkg::cell_ctrl_t ctrl,
    input  logic                 bit_in,
    input  logic [3:0]           digit_in,
    output logic                 carry_out,
    output logic [3:0]           digit
);
    import btda_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adjusted;

    // Add three to a digit of five or more so that doubling carries correctly.
    assign adjusted  = (digit_reg >= DABBLE_LIMIT) ? (digit_reg + DABBLE_ADD) : digit_reg;
    assign carry_out = adjusted[3];
    assign digit     = digit_reg;

    // Next digit value for the requested operation.
    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adjusted[2:0], bit_in};
        end
        else if (ctrl.shift_up)
        begin
            digit_next = digit_in;
        end
    end

    // The digit is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

FILE: rtl/core/btda_chain.sv
// Row of decimal digit cells, least significant digit in cell zero.
module btda_chain #(
    parameter int NUM_CELLS = btda_pkg::DEF_MAX_DIGITS
)
(
    input  logic                 clk,
    input  btda_pkg::cell_ctrl_t ctrl,
    input  logic                 bit_in,
    output logic [3:0]           top_digit,
    output logic                 carry_out
);
    import btda_pkg::*;

    logic [NUM_CELLS-1:0] carry;
    logic [3:0]           digit [NUM_CELLS];

    // Each cell takes its bit and its digit from the neighbor below; cell zero takes the input bit and a zero digit.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        logic       cell_bit;
        logic [3:0] cell_digit_in;

        if (i == 0)
        begin : g_first
            assign cell_bit      = bit_in;
            assign cell_digit_in = '0;
        end
        else
        begin : g_rest
            assign cell_bit      = carry[i-1];
            assign cell_digit_in = digit[i-1];
        end

        btda_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .bit_in    (cell_bit),
            .digit_in  (cell_digit_in),
            .carry_out (carry[i]),
            .digit     (digit[i])
        );
    end

    // The top cell feeds the emitter and reports overflow past the last digit.
    assign top_digit = digit[NUM_CELLS-1];
    assign carry_out = carry[NUM_CELLS-1];

endmodule

FILE: rtl/core/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII text converter.
//
//  channel  | valid      | ready      | payload    | moves
//  ---------+------------+------------+------------+-------------------------------
//  number   | num_valid  | num_ready  | num_data   | sign flag and binary magnitude
//  text     | char_valid | char_ready | char_data  | one ASCII character, last mark
//
// A number is accepted, then shifted through the digit cell chain (one
// magnitude bit per cycle), then its digits are walked out of the top cell,
// with a minus sign sent ahead of them for a nonzero negative number. Leading
// zeros are dropped one per cycle without a request on the text side. The next
// number is accepted once the last character sits in the output register.
// Reset clears the control state; a stalled text side holds the emitter at its
// current digit.
module binary_to_decimal_ascii #(
    parameter int MAGNITUDE_BITS = btda_pkg::DEF_MAGNITUDE_BITS,
    parameter int MAX_DIGITS     = btda_pkg::DEF_MAX_DIGITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    output logic                num_ready,
    input  btda_pkg::num_req_t  num_data,
    output logic                char_valid,
    input  logic                char_ready,
    output btda_pkg::char_req_t char_data
);
    import btda_pkg::*;

    localparam int BIT_CNT_W = $clog2(MAGNITUDE_BITS);
    localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic [MAGNITUDE_BITS-1:0] mag_reg, mag_next;
    logic [BIT_CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]      dig_cnt_reg, dig_cnt_next;
    logic                      sign_reg, sign_next;
    logic                      ovf_reg, ovf_next;
    logic                      lead_reg, lead_next;
    logic                      out_valid_reg, out_valid_next;
    char_req_t                 out_data_reg, out_data_next;

    cell_ctrl_t                ctrl;
    logic [3:0]                top_digit;
    logic                      chain_carry;
    logic                      accept;
    logic                      can_load;
    logic                      load;

    // Digit cell row doing the binary to decimal conversion.
    btda_chain #(
        .NUM_CELLS (MAX_DIGITS)
    ) u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (mag_reg[MAGNITUDE_BITS-1]),
        .top_digit (top_digit),
        .carry_out (chain_carry)
    );

    assign num_ready  = (state_reg == ST_IDLE);
    assign accept     = num_valid && num_ready;
    assign can_load   = !out_valid_reg || char_ready;
    assign char_valid = out_valid_reg;
    assign char_data  = out_data_reg;

    // Sequencer: accept, convert bit by bit, then emit characters.
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        sign_next      = sign_reg;
        ovf_next       = ovf_reg;
        lead_next      = lead_reg;
        out_data_next  = out_data_reg;
        load           = 1'b0;
        ctrl           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mag_next     = num_data.magnitude[MAGNITUDE_BITS-1:0];
                    sign_next    = num_data.is_negative
                                   && (|num_data.magnitude[MAGNITUDE_BITS-1:0]);
                    bit_cnt_next = BIT_CNT_W'(MAGNITUDE_BITS - 1);
                    ovf_next     = 1'b0;
                    ctrl.clear   = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // One magnitude bit enters the cell row per cycle.
                ctrl.dabble  = 1'b1;
                mag_next     = {mag_reg[MAGNITUDE_BITS-2:0], 1'b0};
                ovf_next     = ovf_reg || chain_carry;
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_CNT_W'(MAX_DIGITS);
                    lead_next    = !(ovf_reg || chain_carry);
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sign_reg)
                begin
                    // The minus sign goes out ahead of the digits.
                    if (can_load)
                    begin
                        load                    = 1'b1;
                        out_data_next.text_char = ASCII_MINUS;
                        out_data_next.last_char = 1'b0;
                        sign_next               = 1'b0;
                    end
                end
                else if (lead_reg && (top_digit == '0) && (dig_cnt_reg > DIG_CNT_W'(1)))
                begin
                    // Drop a leading zero, keeping at least one digit.
                    ctrl.shift_up = 1'b1;
                    dig_cnt_next  = dig_cnt_reg - DIG_CNT_W'(1);
                end
                else if (can_load)
                begin
                    load                    = 1'b1;
                    out_data_next.text_char = ASCII_ZERO + {2'b00, top_digit};
                    out_data_next.last_char = (dig_cnt_reg == DIG_CNT_W'(1));
                    ctrl.shift_up           = 1'b1;
                    dig_cnt_next            = dig_cnt_reg - DIG_CNT_W'(1);
                    lead_next               = 1'b0;
                    if (dig_cnt_reg == DIG_CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register holds a character until the text side takes it.
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (char_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            sign_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            lead_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            sign_reg      <= sign_next;
            ovf_reg       <= ovf_next;
            lead_reg      <= lead_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        out_data_reg <= out_data_next;
    end

    // A minus sign is never the final character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.text_char == ASCII_MINUS)) |-> !out_data_reg.last_char)
        else $error("minus sign marked as last character");

    // Finishing a number leaves its last character in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && $past(state_reg == ST_EMIT))
            |-> (out_valid_reg && out_data_reg.last_char))
        else $error("emitter returned to idle without a last character");

    // No sign is left pending once the block is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !sign_reg)
        else $error("minus sign pending while idle");

    // The emitter always has at least one digit left to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (dig_cnt_reg != '0))
        else $error("emitter ran out of digits");

endmodule
